/* rtl/volume_transfer_composite_core_defines.svh */
// assertion macros for the volume transfer compositor checker
`ifndef VOLUME_TRANSFER_COMPOSITE_CORE_DEFINES_SVH
`define VOLUME_TRANSFER_COMPOSITE_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define VTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vtc check failed");

// consequent checked in the cycle after the antecedent
`define VTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vtc check failed");

`endif

/* rtl/vtc_pkg.sv */
// types, constants and fixed-point helpers of the volume transfer compositor
`default_nettype none

package vtc_pkg;

  localparam int unsigned LUT_DEPTH = 256;
  localparam int unsigned LUT_AW    = $clog2(LUT_DEPTH);
  localparam logic [32:0] LUT_LAST  = 33'(LUT_DEPTH - 1);
  localparam int unsigned CFG_AW    = 4;

  localparam logic [15:0] ONE        = 16'd32768;
  localparam logic [15:0] HI_LOW     = 16'd21300;
  localparam logic [15:0] MID_HIGH   = 16'd21299;
  localparam logic [15:0] MID_LOW    = 16'd16384;
  localparam logic [15:0] LO_LOW     = 16'd9831;
  localparam logic [15:0] MED_LIMIT  = 16'd26214;
  localparam logic [15:0] COLOR_0P6  = 16'd19661;
  localparam logic [15:0] COLOR_0P9  = 16'd29491;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    MODE_SEISMIC   = 3'd0,
    MODE_MEDICAL   = 3'd1,
    MODE_SEIS_COMP = 3'd2,
    MODE_CHEM      = 3'd3,
    MODE_BLEND     = 3'd4,
    MODE_RGB       = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE         = 2'd0,
    REG_LUT_OFFSET   = 2'd1,
    REG_MAX_INDEX    = 2'd2,
    REG_GLOBAL_ALPHA = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MIX
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] lut_offset;
    logic [7:0]         max_lut_index;
    logic [15:0]        global_alpha;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  table_index;
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
    logic [15:0] color_alpha;
    logic [31:0] sample_value;
    logic        last_sample;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } out_word_t;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [15:0] a;
  } rgba_t;

  function automatic logic [15:0] sat1(logic [15:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic rgba_t word_color(in_word_t w);
    rgba_t c;
    c.r = sat1(w.color_red);
    c.g = sat1(w.color_green);
    c.b = sat1(w.color_blue);
    c.a = sat1(w.color_alpha);
    return c;
  endfunction

  function automatic logic [15:0] fmul(logic [15:0] x, logic [15:0] y);
    logic [31:0] p;
    p = x * y + 32'd16384;
    return p[30:15];
  endfunction

  // a*s + (1-a)*c rewritten as a*(s-c) + c
  function automatic logic [15:0] mix(logic [15:0] a, logic [15:0] s, logic [15:0] c);
    logic signed [16:0] d;
    logic signed [34:0] acc;
    d   = $signed({1'b0, s}) - $signed({1'b0, c});
    acc = $signed({1'b0, a}) * d + $signed({4'd0, c, 15'd0}) + 35'sd16384;
    return acc[30:15];
  endfunction

  function automatic logic [15:0] alpha_over(logic [15:0] a, logic [15:0] alpha);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, fmul(ONE - a, alpha)};
    return (sum > {1'b0, ONE}) ? ONE : sum[15:0];
  endfunction

  function automatic logic [15:0] band(logic [15:0] t, logic [15:0] c, logic [15:0] hi,
                                       logic [15:0] mid, logic [15:0] lo);
    if (t >= HI_LOW && t < ONE) return hi;
    else if (t > MID_LOW && t <= MID_HIGH) return mid;
    else if (t >= LO_LOW && t < MID_LOW) return lo;
    else return c;
  endfunction

  function automatic logic [15:0] medmax(logic [15:0] t, logic [15:0] c);
    if (t <= MED_LIMIT && t > c) return t;
    else return c;
  endfunction

  // (v*32768 + 127) / 255 as 128*v + (128*v + 127) / 255
  function automatic logic [15:0] byte_to_fix(logic [7:0] v);
    logic [15:0] x;
    logic [15:0] q;
    x = {1'b0, v, 7'h7f};
    q = x + 16'd1 + {8'd0, x[15:8]};
    return {1'b0, v, 7'd0} + {8'd0, q[15:8]};
  endfunction

  function automatic logic [LUT_AW-1:0] lut_addr(logic signed [32:0] idx,
                                                 logic [7:0] max_idx);
    logic [32:0] lim;
    lim = ({25'd0, max_idx} > LUT_LAST) ? LUT_LAST : {25'd0, max_idx};
    if (idx < 0) return '0;
    else if ($unsigned(idx) > lim) return LUT_AW'(lim);
    else return LUT_AW'($unsigned(idx));
  endfunction

  function automatic logic lut_in_range(logic [7:0] idx);
    return {25'd0, idx} <= LUT_LAST;
  endfunction

endpackage

`default_nettype wire

/* rtl/vtc_lut_ram.sv */
// single-port-write, registered-read color table memory
`default_nettype none

module vtc_lut_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/vtc_cfg_regs.sv */
// configuration registers behind the register bus port
`default_nettype none

module vtc_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vtc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output vtc_pkg::cfg_t             cfg_o
);

  import vtc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  reg_e sel;
  logic wr_en;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_MODE:         cfg_d.mode          = pwdata[2:0];
        REG_LUT_OFFSET:   cfg_d.lut_offset    = $signed(pwdata[15:0]);
        REG_MAX_INDEX:    cfg_d.max_lut_index = pwdata[7:0];
        REG_GLOBAL_ALPHA: cfg_d.global_alpha  = pwdata[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_MODE:         prdata = {29'd0, cfg_q.mode};
      REG_LUT_OFFSET:   prdata = {16'd0, cfg_q.lut_offset};
      REG_MAX_INDEX:    prdata = {24'd0, cfg_q.max_lut_index};
      REG_GLOBAL_ALPHA: prdata = {16'd0, cfg_q.global_alpha};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_SEISMIC;
      cfg_q.lut_offset    <= '0;
      cfg_q.max_lut_index <= 8'd255;
      cfg_q.global_alpha  <= ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/vtc_shade.sv */
// per-sample shading: opacity product stage and color update by mode
`default_nettype none

module vtc_shade (
  input  logic           clk_i,
  input  logic           cap_i,
  input  vtc_pkg::cfg_t  cfg_i,
  input  vtc_pkg::rgba_t lut_i,
  input  logic [31:0]    raw_i,
  input  vtc_pkg::rgba_t color_i,
  output vtc_pkg::rgba_t color_o
);

  import vtc_pkg::*;

  logic [15:0] ga;
  rgba_t       src_d;
  rgba_t       src_q;
  logic [15:0] a_d;
  logic [15:0] a_q;

  assign ga = sat1(cfg_i.global_alpha);

  // source color and opacity, one multiply ahead of the blend
  always_comb begin
    if (cfg_i.mode == MODE_RGB) begin
      src_d.r = byte_to_fix(raw_i[31:24]);
      src_d.g = byte_to_fix(raw_i[23:16]);
      src_d.b = byte_to_fix(raw_i[15:8]);
      src_d.a = ga;
      a_d     = ga;
    end else begin
      src_d = lut_i;
      a_d   = fmul(lut_i.a, ga);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      src_q <= src_d;
      a_q   <= a_d;
    end
  end

  always_comb begin
    case (cfg_i.mode) inside
      MODE_MEDICAL: begin
        color_o.r = medmax(src_q.r, color_i.r);
        color_o.g = medmax(src_q.g, color_i.g);
        color_o.b = medmax(src_q.b, color_i.b);
        color_o.a = a_q;
      end
      MODE_SEIS_COMP, MODE_CHEM, MODE_RGB: begin
        color_o.r = mix(a_q, src_q.r, color_i.r);
        color_o.g = mix(a_q, src_q.g, color_i.g);
        color_o.b = mix(a_q, src_q.b, color_i.b);
        color_o.a = alpha_over(a_q, color_i.a);
      end
      MODE_BLEND: begin
        color_o.r = mix(src_q.a, src_q.r, color_i.r);
        color_o.g = mix(src_q.a, src_q.g, color_i.g);
        color_o.b = mix(src_q.a, src_q.b, color_i.b);
        color_o.a = a_q;
      end
      default: begin
        color_o.r = band(src_q.r, color_i.r, '0, COLOR_0P9, COLOR_0P6);
        color_o.g = band(src_q.g, color_i.g, '0, COLOR_0P9, '0);
        color_o.b = band(src_q.b, color_i.b, COLOR_0P6, COLOR_0P9, '0);
        color_o.a = ga;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/volume_transfer_composite_core.sv */
// volume ray compositor with color transfer table, top level
// load and start words leave the block free for the next word; a sample word has these steps:
// table read, opacity product, color blend and write-back of the ray color
// a last sample puts its result in the output register when its blend is written back
// the next word is taken while a result waits; a last sample stalls only if a result still waits
// reset zeroes the ray color and sets register defaults; the table is not cleared
`default_nettype none

module volume_transfer_composite_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  vtc_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output vtc_pkg::out_word_t        out_word_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vtc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import vtc_pkg::*;

  cfg_t              cfg;
  state_e            state_q;
  state_e            state_d;
  rgba_t             color_q;
  rgba_t             color_d;
  rgba_t             shade_color;
  logic [31:0]       smp_q;
  logic [31:0]       smp_d;
  logic              last_q;
  logic              last_d;
  logic              out_valid_q;
  logic              out_valid_d;
  out_word_t         out_q;
  out_word_t         out_d;
  logic              accept;
  logic              out_free;
  logic              shade_cap;
  logic              lut_we;
  logic              lut_re;
  logic [LUT_AW-1:0] lut_raddr;
  rgba_t             lut_rdata;
  logic signed [32:0] idx;

  vtc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vtc_lut_ram #(
    .Depth (LUT_DEPTH),
    .Width ($bits(rgba_t))
  ) u_lut (
    .clk_i   (clk_i),
    .we_i    (lut_we),
    .waddr_i (LUT_AW'(in_word_i.table_index)),
    .wdata_i (word_color(in_word_i)),
    .re_i    (lut_re),
    .raddr_i (lut_raddr),
    .rdata_o (lut_rdata)
  );

  vtc_shade u_shade (
    .clk_i   (clk_i),
    .cap_i   (shade_cap),
    .cfg_i   (cfg),
    .lut_i   (lut_rdata),
    .raw_i   (smp_q),
    .color_i (color_q),
    .color_o (shade_color)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    if (cfg.mode == MODE_BLEND) begin
      idx = $signed({in_word_i.sample_value[31], in_word_i.sample_value});
    end else begin
      idx = $signed({in_word_i.sample_value[31], in_word_i.sample_value})
          - $signed({{17{cfg.lut_offset[15]}}, cfg.lut_offset});
    end
  end

  assign lut_raddr = lut_addr(idx, cfg.max_lut_index);

  // the ray color is written back before the next word is taken
  always_comb begin
    state_d     = state_q;
    color_d     = color_q;
    smp_d       = smp_q;
    last_d      = last_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    lut_we      = 1'b0;
    lut_re      = 1'b0;
    shade_cap   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_word_i.opcode == OP_LOAD) begin
            lut_we = lut_in_range(in_word_i.table_index);
          end else if (in_word_i.opcode == OP_START) begin
            color_d = word_color(in_word_i);
          end else if (in_word_i.opcode == OP_SAMPLE) begin
            lut_re  = 1'b1;
            smp_d   = in_word_i.sample_value;
            last_d  = in_word_i.last_sample;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        shade_cap = 1'b1;
        state_d   = ST_MIX;
      end
      ST_MIX: begin
        if (!last_q || out_free) begin
          color_d = shade_color;
          state_d = ST_IDLE;
          if (last_q) begin
            out_valid_d       = 1'b1;
            out_d.out_red     = shade_color.r;
            out_d.out_green   = shade_color.g;
            out_d.out_blue    = shade_color.b;
            out_d.out_alpha   = shade_color.a;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      color_q     <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

/* rtl/vtc_core_checker.sv */
// port-level checks of the volume transfer compositor, bound to the top level
`default_nettype none

`include "volume_transfer_composite_core_defines.svh"

module vtc_core_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input vtc_pkg::in_word_t in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i
);

  import vtc_pkg::*;

  // a held result stays offered
  `VTC_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

  // a sample occupies the block for the table read
  `VTC_ASSERT_NEXT(a_sample_busy,
    in_valid_i && !in_stall_o && in_word_i.opcode == OP_SAMPLE, in_stall_o)

  // load, start and spare-opcode words never hold off the next word
  `VTC_ASSERT_NEXT(a_other_free,
    in_valid_i && !in_stall_o && in_word_i.opcode != OP_SAMPLE, !in_stall_o)

  // a new result only ends a sample in progress
  `VTC_ASSERT_NOW(a_result_from_sample, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind volume_transfer_composite_core vtc_core_checker u_checker (.*);

`default_nettype wire

/* sim/volume_transfer_composite_core_tb.sv */
// self-checking testbench for the volume transfer compositor: queued stimulus, predictor, checker
`default_nettype none

module volume_transfer_composite_core_tb;
  import vtc_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PHASE_WORDS = 55;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_word_t           in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_word_t          out_word_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  volume_transfer_composite_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  rgba_t     ray_m;
  rgba_t     lut_m [LUT_DEPTH];
  cfg_t      cfg_m;
  out_word_t color_due [$];

  in_word_t  pending_words [$];
  int        pushed_count = 0;
  int        taken_count = 0;
  int        results_due = 0;
  int        mismatches = 0;
  int        send_gap = 0;
  int        hold_gap = 0;
  bit        calm = 1'b0;
  bit        in_taken = 1'b0;

  logic [15:0] level_marks [13] = '{16'd0, 16'd1, 16'd9830, 16'd9831, 16'd16383, 16'd16384,
                                    16'd16385, 16'd21299, 16'd21300, 16'd26214, 16'd26215,
                                    16'd32767, 16'd32768};
  logic [2:0]  mode_list [8] = '{MODE_SEISMIC, MODE_MEDICAL, MODE_SEIS_COMP, MODE_CHEM,
                                 MODE_BLEND, MODE_RGB, MODE_SPARE6, MODE_SPARE7};

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // fixed-point arithmetic, 1.0 = 32768
  function automatic logic [15:0] clip_one(logic [31:0] v);
    return (v > 32'(ONE)) ? ONE : v[15:0];
  endfunction

  function automatic logic [15:0] fx_mul(logic [15:0] x, logic [15:0] y);
    return 16'((64'(x) * 64'(y) + 64'd16384) >> 15);
  endfunction

  function automatic logic [15:0] fx_lerp(logic [15:0] w, logic [15:0] s, logic [15:0] c);
    return 16'((64'(w) * 64'(s) + (64'(ONE) - 64'(w)) * 64'(c) + 64'd16384) >> 15);
  endfunction

  function automatic logic [15:0] byte_level(logic [7:0] v);
    return 16'((64'(v) * 64'd32768 + 64'd127) / 64'd255);
  endfunction

  function automatic logic [15:0] band_pick(logic [15:0] t, logic [15:0] c, logic [15:0] hi,
                                            logic [15:0] mid, logic [15:0] lo);
    if (t >= HI_LOW && t < ONE) return hi;
    if (t > MID_LOW && t <= MID_HIGH) return mid;
    if (t >= LO_LOW && t < MID_LOW) return lo;
    return c;
  endfunction

  function automatic logic [15:0] brighter(logic [15:0] t, logic [15:0] c);
    if (t <= MED_LIMIT && t > c) return t;
    return c;
  endfunction

  function automatic void composite_over(rgba_t s, logic [15:0] a);
    ray_m.r = fx_lerp(a, s.r, ray_m.r);
    ray_m.g = fx_lerp(a, s.g, ray_m.g);
    ray_m.b = fx_lerp(a, s.b, ray_m.b);
    ray_m.a = clip_one(32'(a) + 32'(fx_mul(ONE - a, ray_m.a)));
  endfunction

  function automatic rgba_t clipped_color(in_word_t w);
    rgba_t c;
    c.r = clip_one(32'(w.color_red));
    c.g = clip_one(32'(w.color_green));
    c.b = clip_one(32'(w.color_blue));
    c.a = clip_one(32'(w.color_alpha));
    return c;
  endfunction

  // applies one accepted word to the model (table load, ray start or sample) and queues the color a last sample emits
  function automatic void absorb_word(in_word_t w);
    longint      s;
    longint      idx;
    rgba_t       t;
    rgba_t       src;
    logic [15:0] ga;
    out_word_t   res;
    ga = clip_one(32'(cfg_m.global_alpha));
    if (w.opcode == OP_LOAD) begin
      if (int'(w.table_index) < LUT_DEPTH) lut_m[w.table_index] = clipped_color(w);
      return;
    end
    if (w.opcode == OP_START) begin
      ray_m = clipped_color(w);
      return;
    end
    if (w.opcode != OP_SAMPLE) return;
    s = longint'($signed(w.sample_value));
    idx = (cfg_m.mode == MODE_BLEND) ? s : s - longint'(cfg_m.lut_offset);
    if (idx < 0) idx = 0;
    if (idx > longint'(cfg_m.max_lut_index)) idx = longint'(cfg_m.max_lut_index);
    if (idx > LUT_DEPTH - 1) idx = LUT_DEPTH - 1;
    t = lut_m[idx];
    case (cfg_m.mode)
      MODE_MEDICAL: begin
        ray_m.b = brighter(t.b, ray_m.b);
        ray_m.g = brighter(t.g, ray_m.g);
        ray_m.r = brighter(t.r, ray_m.r);
        ray_m.a = fx_mul(t.a, ga);
      end
      MODE_SEIS_COMP, MODE_CHEM: composite_over(t, fx_mul(t.a, ga));
      MODE_BLEND: begin
        ray_m.b = fx_lerp(t.a, t.b, ray_m.b);
        ray_m.g = fx_lerp(t.a, t.g, ray_m.g);
        ray_m.r = fx_lerp(t.a, t.r, ray_m.r);
        ray_m.a = fx_mul(t.a, ga);
      end
      MODE_RGB: begin
        src.r = byte_level(w.sample_value[31:24]);
        src.g = byte_level(w.sample_value[23:16]);
        src.b = byte_level(w.sample_value[15:8]);
        src.a = ga;
        composite_over(src, ga);
      end
      default: begin
        ray_m.b = band_pick(t.b, ray_m.b, COLOR_0P6, COLOR_0P9, 16'd0);
        ray_m.g = band_pick(t.g, ray_m.g, 16'd0, COLOR_0P9, 16'd0);
        ray_m.r = band_pick(t.r, ray_m.r, 16'd0, COLOR_0P9, COLOR_0P6);
        ray_m.a = ga;
      end
    endcase
    if (w.last_sample) begin
      res.out_red = ray_m.r;
      res.out_green = ray_m.g;
      res.out_blue = ray_m.b;
      res.out_alpha = ray_m.a;
      color_due.push_back(res);
      results_due++;
    end
  endfunction

  function automatic void compare_channel(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_color(out_word_t got);
    out_word_t want;
    if (color_due.size() == 0) begin
      mismatches++;
      $display("%0t result expected none actual %h", $time, got);
      return;
    end
    want = color_due.pop_front();
    results_due--;
    compare_channel("red", want.out_red, got.out_red);
    compare_channel("green", want.out_green, got.out_green);
    compare_channel("blue", want.out_blue, got.out_blue);
    compare_channel("alpha", want.out_alpha, got.out_alpha);
  endfunction

  // monitor
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      absorb_word(in_word_i);
      taken_count++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) check_color(out_word_o);
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) hold_gap = $urandom_range(1, 5);
      end
    end
  end

  // stimulus helpers
  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(0, 32768));
      4, 5, 6, 7: return level_marks[$urandom_range(0, 12)];
      8: return 16'($urandom);
      default: return ONE;
    endcase
  endfunction

  function automatic in_word_t noise_word();
    logic [127:0] noise;
    in_word_t     w;
    noise = {$urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t load_word(logic [7:0] idx);
    in_word_t w;
    w = noise_word();
    w.opcode = OP_LOAD;
    w.table_index = idx;
    w.color_red = pick_level();
    w.color_green = pick_level();
    w.color_blue = pick_level();
    w.color_alpha = pick_level();
    return w;
  endfunction

  function automatic in_word_t start_word();
    in_word_t w;
    w = load_word(8'($urandom));
    w.opcode = OP_START;
    return w;
  endfunction

  function automatic in_word_t sample_word(logic [31:0] v, logic last);
    in_word_t w;
    w = noise_word();
    w.opcode = OP_SAMPLE;
    w.sample_value = v;
    w.last_sample = last;
    return w;
  endfunction

  function automatic logic [31:0] pick_sample();
    longint base;
    base = (cfg_m.mode == MODE_BLEND) ? 0 : longint'(cfg_m.lut_offset);
    if (cfg_m.mode == MODE_RGB || $urandom_range(0, 7) == 0) return $urandom;
    return 32'(base + longint'($urandom_range(0, int'(cfg_m.max_lut_index) + 3)) - 2);
  endfunction

  function automatic void queue_word(in_word_t w);
    pending_words.push_back(w);
    pushed_count++;
  endfunction

  function automatic void queue_rays(int count);
    int       made;
    int       n;
    in_word_t w;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          queue_word(load_word(8'($urandom)));
          made++;
        end
        2: begin
          w = noise_word();
          w.opcode = OP_SPARE;
          queue_word(w);
        end
        default: begin
          if ($urandom_range(0, 7) != 0) begin
            queue_word(start_word());
            made++;
          end
          n = $urandom_range(1, 6);
          for (int k = 0; k < n; k++) begin
            queue_word(sample_word(pick_sample(), k == n - 1));
            made++;
          end
        end
      endcase
    end
  endfunction

  task automatic write_reg(reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      REG_MODE:         cfg_m.mode = v[2:0];
      REG_LUT_OFFSET:   cfg_m.lut_offset = v[15:0];
      REG_MAX_INDEX:    cfg_m.max_lut_index = v[7:0];
      REG_GLOBAL_ALPHA: cfg_m.global_alpha = v[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for every queued word and every expected color, then let the pipeline empty
  task automatic settle();
    wait (taken_count == pushed_count && results_due == 0);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    in_word_t w;
    ray_m = '0;
    cfg_m.mode = MODE_SEISMIC;
    cfg_m.lut_offset = '0;
    cfg_m.max_lut_index = 8'd255;
    cfg_m.global_alpha = ONE;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the whole table so no unwritten entry is ever read
    for (int i = 0; i < LUT_DEPTH; i++) queue_word(load_word(8'(i)));

    // directed: every mode at its index extremes, saturated and zero start colors
    for (int m = 0; m < 8; m++) begin
      if (m != 0) begin
        settle();
        write_reg(REG_MODE, 32'(mode_list[m]));
      end
      w = start_word();
      w.color_red = (m % 2 == 0) ? 16'hffff : 16'd0;
      w.color_green = w.color_red;
      w.color_blue = w.color_red;
      w.color_alpha = (m % 2 == 0) ? 16'hffff : ONE;
      queue_word(w);
      queue_word(sample_word(32'h8000_0000, 1'b0));
      queue_word(sample_word(32'h7fff_ffff, 1'b1));
    end
    w = noise_word();
    w.opcode = OP_SPARE;
    queue_word(w);
    queue_word(sample_word(32'h0000_0080, 1'b1));

    // random phases, sender held off between them
    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm = (p == PHASES - 1);
      write_reg(REG_MODE, 32'($urandom_range(0, 7)));
      case (p % 4)
        0: write_reg(REG_LUT_OFFSET, 32'h0000_8000);
        1: write_reg(REG_LUT_OFFSET, 32'h0000_7fff);
        2: write_reg(REG_LUT_OFFSET, {16'd0, 16'($urandom)});
        default: write_reg(REG_LUT_OFFSET, {16'd0, 16'($urandom_range(0, 600) - 300)});
      endcase
      case (p % 3)
        0: write_reg(REG_MAX_INDEX, 32'd0);
        1: write_reg(REG_MAX_INDEX, 32'd255);
        default: write_reg(REG_MAX_INDEX, 32'($urandom_range(0, 255)));
      endcase
      case (p % 5)
        0: write_reg(REG_GLOBAL_ALPHA, 32'd0);
        1: write_reg(REG_GLOBAL_ALPHA, 32'(ONE));
        2: write_reg(REG_GLOBAL_ALPHA, 32'($urandom_range(32769, 65535)));
        default: write_reg(REG_GLOBAL_ALPHA, 32'($urandom_range(0, 32768)));
      endcase
      queue_rays(PHASE_WORDS);
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* volume_transfer_composite_core.f */
+incdir+rtl
rtl/vtc_pkg.sv
rtl/vtc_lut_ram.sv
rtl/vtc_cfg_regs.sv
rtl/vtc_shade.sv
rtl/volume_transfer_composite_core.sv
rtl/vtc_core_checker.sv
sim/volume_transfer_composite_core_tb.sv
